// File: design/assert_macros.svh
// Assertion macros shared by the partial volume fraction RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, held off while reset is high.
`define PVF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pvf: assertion failed");
// Check a property on every rising edge, reset included.
`define PVF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pvf: assertion failed");
`else
`define PVF_ASSERT(lbl, clk, rst, prop)
`define PVF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/pvf_pkg.sv
// Package for the partial volume fraction block: field widths, tissue codes,
// register indexes and the types shared by the pipeline modules. No dependencies.
package pvf_pkg;

   localparam int INT_W  = 16;
   localparam int CODE_W = 3;
   localparam int PROB_W = 8;
   localparam int IDX_W  = 2;

   // Tissue codes on the input channel; anything else is background
   localparam logic [CODE_W-1:0] CODE_BG     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_CSF    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_GM_CSF = 3'd2;
   localparam logic [CODE_W-1:0] CODE_GM     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_WM_GM  = 3'd4;
   localparam logic [CODE_W-1:0] CODE_WM     = 3'd5;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] REG_MEAN_CSF = 2'd0;
   localparam logic [IDX_W-1:0] REG_MEAN_GM  = 2'd1;
   localparam logic [IDX_W-1:0] REG_MEAN_WM  = 2'd2;

   // Output constants
   localparam logic [PROB_W-1:0] PROB_FULL   = 8'd255;
   localparam logic [PROB_W-1:0] LABEL_CSF   = 8'd85;
   localparam logic [PROB_W-1:0] LABEL_GM    = 8'd170;
   localparam logic [PROB_W-1:0] LABEL_WM    = 8'd255;
   localparam int                SCALE_PROB  = 255;
   localparam int                SCALE_LABEL = 85;

   typedef enum logic [2:0] {
      MODE_BG,
      MODE_CSF,
      MODE_GM,
      MODE_WM,
      MODE_MIX_GC,
      MODE_MIX_WG
   } mode_type;

   // How the mixing fraction is settled: fixed zero, fixed one, or the quotient
   typedef enum logic [1:0] {
      FRAC_ZERO,
      FRAC_ONE,
      FRAC_DIV
   } frac_type;

   typedef struct packed {
      mode_type mode;
      frac_type frac;
      logic     last;
   } tag_type;

   typedef struct packed {
      logic [INT_W-1:0] mean_csf;
      logic [INT_W-1:0] mean_gm;
      logic [INT_W-1:0] mean_wm;
   } means_type;

endpackage

// File: design/pvf_req_if.sv
// Voxel request channel: valid/ready handshake with intensity, code and last flag.
// Depends on pvf_pkg for field widths.
interface pvf_req_if;
   logic                        valid;
   logic                        ready;
   logic [pvf_pkg::INT_W-1:0]   intensity;
   logic [pvf_pkg::CODE_W-1:0]  tissue_code;
   logic                        last_voxel;

   modport source (output valid, intensity, tissue_code, last_voxel, input ready);
   modport sink   (input valid, intensity, tissue_code, last_voxel, output ready);
endinterface

// File: design/pvf_rsp_if.sv
// Result channel: valid/ready handshake with three probabilities, label and last.
// Depends on pvf_pkg for field widths.
interface pvf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pvf_pkg::PROB_W-1:0]  prob_csf;
   logic [pvf_pkg::PROB_W-1:0]  prob_gm;
   logic [pvf_pkg::PROB_W-1:0]  prob_wm;
   logic [pvf_pkg::PROB_W-1:0]  pve_label;
   logic                        last;

   modport source (output valid, prob_csf, prob_gm, prob_wm, pve_label, last, input ready);
   modport sink   (input valid, prob_csf, prob_gm, prob_wm, pve_label, last, output ready);
endinterface

// File: design/pvf_csr_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on pvf_pkg for widths.
interface pvf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pvf_pkg::IDX_W-1:0]   index;
   logic [pvf_pkg::INT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/pvf_front.sv
// Operand stage: decodes the tissue code, forms offset and divisor magnitudes
// and settles the special cases of the fraction. Depends on pvf_pkg.
module pvf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [pvf_pkg::INT_W-1:0]  intensity,
   input  logic [pvf_pkg::CODE_W-1:0] tissue_code,
   input  logic                       last_voxel,
   input  pvf_pkg::means_type         means,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pvf_pkg::tag_type           out_tag,
   output logic [pvf_pkg::INT_W-1:0]  out_rem,
   output logic [pvf_pkg::INT_W-1:0]  out_den
);

   logic                       valid_ff;
   pvf_pkg::tag_type           tag_ff, tag_in;
   pvf_pkg::mode_type          mode_in;
   pvf_pkg::frac_type          frac_in;
   logic [pvf_pkg::INT_W-1:0]  rem_ff, rem_in;
   logic [pvf_pkg::INT_W-1:0]  den_ff, den_in;
   logic [pvf_pkg::INT_W-1:0]  mean_lo, mean_hi;
   logic [pvf_pkg::INT_W:0]    num, den;
   logic                       num_neg, den_neg;

   // Decode the code into a mode and pick the two class means of a mix
   always_comb begin
      mean_lo = means.mean_gm;
      mean_hi = means.mean_wm;
      unique case (tissue_code)
         pvf_pkg::CODE_CSF: mode_in = pvf_pkg::MODE_CSF;
         pvf_pkg::CODE_GM:  mode_in = pvf_pkg::MODE_GM;
         pvf_pkg::CODE_WM:  mode_in = pvf_pkg::MODE_WM;
         pvf_pkg::CODE_GM_CSF: begin
            mode_in = pvf_pkg::MODE_MIX_GC;
            mean_lo = means.mean_csf;
            mean_hi = means.mean_gm;
         end
         pvf_pkg::CODE_WM_GM: mode_in = pvf_pkg::MODE_MIX_WG;
         default:             mode_in = pvf_pkg::MODE_BG;
      endcase
   end

   // Signed offset and divisor, then their magnitudes
   always_comb begin
      num     = {1'b0, intensity} - {1'b0, mean_lo};
      den     = {1'b0, mean_hi} - {1'b0, mean_lo};
      num_neg = num[pvf_pkg::INT_W];
      den_neg = den[pvf_pkg::INT_W];
      rem_in  = num_neg ? pvf_pkg::INT_W'(-num) : num[pvf_pkg::INT_W-1:0];
      den_in  = den_neg ? pvf_pkg::INT_W'(-den) : den[pvf_pkg::INT_W-1:0];
   end

   // Settle the clamped and degenerate cases; only a proper fraction divides
   always_comb begin
      if (den == '0) begin
         frac_in = (!num_neg && num != '0) ? pvf_pkg::FRAC_ONE : pvf_pkg::FRAC_ZERO;
      end else if (num == '0 || num_neg != den_neg) begin
         frac_in = pvf_pkg::FRAC_ZERO;
      end else if (rem_in >= den_in) begin
         frac_in = pvf_pkg::FRAC_ONE;
      end else begin
         frac_in = pvf_pkg::FRAC_DIV;
      end
   end

   assign tag_in = '{mode: mode_in, frac: frac_in, last: last_voxel};

   assign in_ready = !valid_ff || out_ready;

   // Advance the stage whenever it is empty or its beat moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff <= tag_in;
         rem_ff <= rem_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;

endmodule

// File: design/pvf_div_cell.sv
// One cell of the restoring divider chain: doubles the partial remainder,
// subtracts the divisor when it fits and shifts one quotient bit in. Uses pvf_pkg.
`include "assert_macros.svh"
module pvf_div_cell #(
   parameter int QW = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  pvf_pkg::tag_type           in_tag,
   input  logic [pvf_pkg::INT_W-1:0]  in_rem,
   input  logic [pvf_pkg::INT_W-1:0]  in_den,
   input  logic [QW-1:0]              in_quo,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pvf_pkg::tag_type           out_tag,
   output logic [pvf_pkg::INT_W-1:0]  out_rem,
   output logic [pvf_pkg::INT_W-1:0]  out_den,
   output logic [QW-1:0]              out_quo
);

   logic                       valid_ff;
   pvf_pkg::tag_type           tag_ff;
   logic [pvf_pkg::INT_W-1:0]  rem_ff, rem_in;
   logic [pvf_pkg::INT_W-1:0]  den_ff;
   logic [QW-1:0]              quo_ff, quo_in;
   logic [pvf_pkg::INT_W:0]    twice, diff;
   logic                       fits;

   // One restoring step
   always_comb begin
      twice  = {in_rem, 1'b0};
      diff   = twice - {1'b0, in_den};
      fits   = twice >= {1'b0, in_den};
      rem_in = fits ? diff[pvf_pkg::INT_W-1:0] : twice[pvf_pkg::INT_W-1:0];
      quo_in = {in_quo[QW-2:0], fits};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff <= in_tag;
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

   // A dividing beat always carries a remainder below its divisor
   `PVF_ASSERT(a_rem_below_den, clock, reset,
      valid_ff && tag_ff.frac == pvf_pkg::FRAC_DIV |-> rem_ff < den_ff)

endmodule

// File: design/pvf_back.sv
// Output stage: forms the clamped fraction, scales it to probabilities and the
// continuous label with half-up rounding, and holds the result beat. Uses pvf_pkg.
module pvf_back #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  pvf_pkg::tag_type             in_tag,
   input  logic [FRACTION_BITS-1:0]     in_quo,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [pvf_pkg::PROB_W-1:0]   prob_csf,
   output logic [pvf_pkg::PROB_W-1:0]   prob_gm,
   output logic [pvf_pkg::PROB_W-1:0]   prob_wm,
   output logic [pvf_pkg::PROB_W-1:0]   pve_label,
   output logic                         last
);

   localparam int WW = FRACTION_BITS + 1;
   localparam int LW = FRACTION_BITS + 2;
   localparam int PW = FRACTION_BITS + 9;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
   localparam logic [WW-1:0] ONE  = WW'(1) << FRACTION_BITS;

   logic                        valid_ff;
   logic [pvf_pkg::PROB_W-1:0]  csf_ff, gm_ff, wm_ff, label_ff, csf_in, gm_in, wm_in, label_in;
   logic                        last_ff;
   logic [WW-1:0]               wq, wq_low;
   logic [LW-1:0]               lsum;
   logic [PW-1:0]               p_hi, p_lo, p_lab;
   logic [pvf_pkg::PROB_W-1:0]  r_hi, r_lo, r_lab;

   // Clamped fraction and its complement
   always_comb begin
      case (in_tag.frac)
         pvf_pkg::FRAC_ONE: wq = ONE;
         pvf_pkg::FRAC_DIV: wq = {1'b0, in_quo};
         default:           wq = '0;
      endcase
      wq_low = ONE - wq;
      lsum   = LW'(wq) + ((in_tag.mode == pvf_pkg::MODE_MIX_WG) ?
                          (LW'(2) << FRACTION_BITS) : (LW'(1) << FRACTION_BITS));
   end

   // Scale and round half up
   always_comb begin
      p_hi  = PW'(wq) * PW'(pvf_pkg::SCALE_PROB) + HALF;
      p_lo  = PW'(wq_low) * PW'(pvf_pkg::SCALE_PROB) + HALF;
      p_lab = PW'(lsum) * PW'(pvf_pkg::SCALE_LABEL) + HALF;
      r_hi  = p_hi[FRACTION_BITS +: pvf_pkg::PROB_W];
      r_lo  = p_lo[FRACTION_BITS +: pvf_pkg::PROB_W];
      r_lab = p_lab[FRACTION_BITS +: pvf_pkg::PROB_W];
   end

   // Route the scaled values by mode
   always_comb begin
      csf_in   = '0;
      gm_in    = '0;
      wm_in    = '0;
      label_in = '0;
      unique case (in_tag.mode)
         pvf_pkg::MODE_CSF: begin
            csf_in   = pvf_pkg::PROB_FULL;
            label_in = pvf_pkg::LABEL_CSF;
         end
         pvf_pkg::MODE_GM: begin
            gm_in    = pvf_pkg::PROB_FULL;
            label_in = pvf_pkg::LABEL_GM;
         end
         pvf_pkg::MODE_WM: begin
            wm_in    = pvf_pkg::PROB_FULL;
            label_in = pvf_pkg::LABEL_WM;
         end
         pvf_pkg::MODE_MIX_GC: begin
            csf_in   = r_lo;
            gm_in    = r_hi;
            label_in = r_lab;
         end
         pvf_pkg::MODE_MIX_WG: begin
            gm_in    = r_lo;
            wm_in    = r_hi;
            label_in = r_lab;
         end
         default: begin
            label_in = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         csf_ff   <= csf_in;
         gm_ff    <= gm_in;
         wm_ff    <= wm_in;
         label_ff <= label_in;
         last_ff  <= in_tag.last;
      end
   end

   assign out_valid = valid_ff;
   assign prob_csf  = csf_ff;
   assign prob_gm   = gm_ff;
   assign prob_wm   = wm_ff;
   assign pve_label = label_ff;
   assign last      = last_ff;

endmodule

// File: design/partial_volume_fraction_voxel.sv
// Top level of the partial volume fraction block: configuration registers,
// operand stage, divider cell chain and output stage. Uses pvf_pkg and the pvf_*_if interfaces.
//
// Usage:
//   req_chan  voxel beats (intensity, tissue_code, last_voxel), valid/ready.
//   rsp_chan  one result beat per voxel, in order (prob_csf, prob_gm, prob_wm,
//             pve_label, last), valid/ready.
//   csr_chan  writes of mean_csf (index 0), mean_gm (1), mean_wm (2); always
//             ready, other indexes ignored. Write only while no voxel is in flight.
//   Throughput is one voxel per cycle while rsp_chan is not stalled. From req
//   acceptance to rsp valid a voxel passes one operand stage, one divider cell per
//   quotient bit and one output stage, with a chain of FRACTION_BITS divider cells.
//   Each stage holds its own valid bit and takes a new beat when it is empty or
//   its beat moves on, so bubbles close up while rsp_chan stalls; req_chan.ready
//   drops only once every stage holds a beat and rsp_chan is stalled.
//   Reset clears the three means to zero and empties the pipeline at once.
`include "assert_macros.svh"
module partial_volume_fraction_voxel #(
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pvf_req_if.sink   req_chan,
   pvf_rsp_if.source rsp_chan,
   pvf_csr_if.sink   csr_chan
);

   logic [pvf_pkg::INT_W-1:0] mean_csf_ff, mean_gm_ff, mean_wm_ff;
   pvf_pkg::means_type        means;

   logic                       st_valid [0:FRACTION_BITS];
   logic                       st_ready [0:FRACTION_BITS];
   pvf_pkg::tag_type           st_tag   [0:FRACTION_BITS];
   logic [pvf_pkg::INT_W-1:0]  st_rem   [0:FRACTION_BITS];
   logic [pvf_pkg::INT_W-1:0]  st_den   [0:FRACTION_BITS];
   logic [FRACTION_BITS-1:0]   st_quo   [0:FRACTION_BITS];

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_csf_ff <= '0;
         mean_gm_ff  <= '0;
         mean_wm_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            pvf_pkg::REG_MEAN_CSF: mean_csf_ff <= csr_chan.data;
            pvf_pkg::REG_MEAN_GM:  mean_gm_ff  <= csr_chan.data;
            pvf_pkg::REG_MEAN_WM:  mean_wm_ff  <= csr_chan.data;
            default: begin
               mean_csf_ff <= mean_csf_ff;
            end
         endcase
      end
   end

   assign means = '{mean_csf: mean_csf_ff, mean_gm: mean_gm_ff, mean_wm: mean_wm_ff};

   // Operand stage
   pvf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .intensity   (req_chan.intensity),
      .tissue_code (req_chan.tissue_code),
      .last_voxel  (req_chan.last_voxel),
      .means       (means),
      .out_valid   (st_valid[0]),
      .out_ready   (st_ready[0]),
      .out_tag     (st_tag[0]),
      .out_rem     (st_rem[0]),
      .out_den     (st_den[0])
   );

   assign st_quo[0] = '0;

   // Divider chain, one quotient bit per cell
   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
      pvf_div_cell #(.QW(FRACTION_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_tag    (st_tag[i]),
         .in_rem    (st_rem[i]),
         .in_den    (st_den[i]),
         .in_quo    (st_quo[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_tag   (st_tag[i+1]),
         .out_rem   (st_rem[i+1]),
         .out_den   (st_den[i+1]),
         .out_quo   (st_quo[i+1])
      );
   end

   // Output stage
   pvf_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[FRACTION_BITS]),
      .in_ready  (st_ready[FRACTION_BITS]),
      .in_tag    (st_tag[FRACTION_BITS]),
      .in_quo    (st_quo[FRACTION_BITS]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .prob_csf  (rsp_chan.prob_csf),
      .prob_gm   (rsp_chan.prob_gm),
      .prob_wm   (rsp_chan.prob_wm),
      .pve_label (rsp_chan.pve_label),
      .last      (rsp_chan.last)
   );

   // Back-pressure reaches the request side only through a stalled result
   `PVF_ASSERT(a_stall_source, clock, reset,
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
   // A write to the GM mean lands in its register
   `PVF_ASSERT(a_gm_written, clock, reset,
      csr_chan.valid && csr_chan.index == pvf_pkg::REG_MEAN_GM
      |=> mean_gm_ff == $past(csr_chan.data))
   // Reset leaves the result channel empty
   `PVF_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_chan.valid)

endmodule

// File: tb/sv/pvf_voxel_checker.sv
// Result checker for partial_volume_fraction_voxel: watches the voxel, result and
// register channels, predicts each result beat and compares it field by field.
// Depends on pvf_pkg and the pvf_req_if, pvf_rsp_if and pvf_csr_if interfaces.
module pvf_voxel_checker #(
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   pvf_req_if   req_mon,
   pvf_rsp_if   rsp_mon,
   pvf_csr_if   csr_mon,
   output int   fail_count,
   output int   awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNITY = longint'(1) << FRACTION_BITS;
   localparam longint HALF  = UNITY >> 1;

   typedef struct {
      logic [pvf_pkg::PROB_W-1:0] csf;
      logic [pvf_pkg::PROB_W-1:0] gm;
      logic [pvf_pkg::PROB_W-1:0] wm;
      logic [pvf_pkg::PROB_W-1:0] label;
      logic                       last;
   } tissue_split_type;

   pvf_pkg::means_type class_means;
   tissue_split_type   pending_splits[$];
   int                 errors = 0;

   assign fail_count = errors;

   // Clamped fraction of (x - lo) / (hi - lo), truncated toward zero
   function automatic longint mix_weight(input logic [pvf_pkg::INT_W-1:0] x, lo, hi);
      longint offset;
      longint span;
      offset = longint'(x) - longint'(lo);
      span   = longint'(hi) - longint'(lo);
      if (span == 0) return (offset > 0) ? UNITY : 0;
      if (offset == 0) return 0;
      if ((offset < 0) != (span < 0)) return 0;
      if (offset < 0) begin
         offset = -offset;
         span   = -span;
      end
      if (offset >= span) return UNITY;
      return (offset << FRACTION_BITS) / span;
   endfunction

   // Scale a fixed-point weight and round half up to an 8-bit value
   function automatic logic [pvf_pkg::PROB_W-1:0] scaled_round(input longint factor,
                                                               input longint w);
      return pvf_pkg::PROB_W'((factor * w + HALF) >> FRACTION_BITS);
   endfunction

   function automatic tissue_split_type split_voxel(input logic [pvf_pkg::INT_W-1:0] x,
                                                    input logic [pvf_pkg::CODE_W-1:0] code,
                                                    input logic last);
      tissue_split_type s;
      longint           w;
      s = '{csf: '0, gm: '0, wm: '0, label: '0, last: last};
      case (code)
         pvf_pkg::CODE_CSF: begin
            s.csf   = pvf_pkg::PROB_FULL;
            s.label = pvf_pkg::LABEL_CSF;
         end
         pvf_pkg::CODE_GM: begin
            s.gm    = pvf_pkg::PROB_FULL;
            s.label = pvf_pkg::LABEL_GM;
         end
         pvf_pkg::CODE_WM: begin
            s.wm    = pvf_pkg::PROB_FULL;
            s.label = pvf_pkg::LABEL_WM;
         end
         pvf_pkg::CODE_GM_CSF: begin
            w       = mix_weight(x, class_means.mean_csf, class_means.mean_gm);
            s.csf   = scaled_round(pvf_pkg::SCALE_PROB, UNITY - w);
            s.gm    = scaled_round(pvf_pkg::SCALE_PROB, w);
            s.label = scaled_round(pvf_pkg::SCALE_LABEL, UNITY + w);
         end
         pvf_pkg::CODE_WM_GM: begin
            w       = mix_weight(x, class_means.mean_gm, class_means.mean_wm);
            s.gm    = scaled_round(pvf_pkg::SCALE_PROB, UNITY - w);
            s.wm    = scaled_round(pvf_pkg::SCALE_PROB, w);
            s.label = scaled_round(pvf_pkg::SCALE_LABEL, 2 * UNITY + w);
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic check_field(input string name, input logic [pvf_pkg::PROB_W-1:0] want,
                              input logic [pvf_pkg::PROB_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // Track register writes, queue predictions, retire result beats in order
   always @(posedge clock) begin
      tissue_split_type got;
      tissue_split_type want;
      if (reset) begin
         class_means = '0;
         pending_splits.delete();
         awaiting <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               pvf_pkg::REG_MEAN_CSF: class_means.mean_csf = csr_mon.data;
               pvf_pkg::REG_MEAN_GM:  class_means.mean_gm  = csr_mon.data;
               pvf_pkg::REG_MEAN_WM:  class_means.mean_wm  = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            pending_splits.push_back(split_voxel(req_mon.intensity, req_mon.tissue_code,
                                                 req_mon.last_voxel));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.prob_csf, rsp_mon.prob_gm, rsp_mon.prob_wm,
                    rsp_mon.pve_label, rsp_mon.last};
            if (pending_splits.size() == 0) begin
               $error("result beat with no voxel outstanding");
               errors++;
            end else begin
               want = pending_splits.pop_front();
               check_field("prob_csf", want.csf, got.csf);
               check_field("prob_gm", want.gm, got.gm);
               check_field("prob_wm", want.wm, got.wm);
               check_field("pve_label", want.label, got.label);
               check_field("last", pvf_pkg::PROB_W'(want.last), pvf_pkg::PROB_W'(got.last));
            end
         end
         awaiting <= pending_splits.size();
      end
   end

endmodule

// File: tb/sv/tb_partial_volume_fraction_voxel.sv
// Testbench top for partial_volume_fraction_voxel: drives voxel beats, register
// writes and result back-pressure, and reports the verdict from pvf_voxel_checker.
// Depends on pvf_pkg, the pvf_*_if interfaces, the block and the checker.
module tb_partial_volume_fraction_voxel;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRACTION_BITS  = 16;
   localparam int LATENCY        = FRACTION_BITS + 2;
   localparam int STALL_LIMIT    = 1000;
   localparam int HOLD_CYCLES    = 120;
   localparam int RANDOM_PHASES  = 9;
   localparam int VOXELS_PER_SET = 205;

   localparam logic [pvf_pkg::IDX_W-1:0]  REG_UNUSED    = 2'd3;
   localparam logic [pvf_pkg::CODE_W-1:0] CODE_SPARE_LO = 3'd6;
   localparam logic [pvf_pkg::CODE_W-1:0] CODE_SPARE_HI = 3'd7;

   logic clock;
   logic reset;

   pvf_req_if req_chan ();
   pvf_rsp_if rsp_chan ();
   pvf_csr_if csr_chan ();

   int                 fail_count;
   int                 awaiting;
   int                 idle_pct = 0;
   int                 quiet_cycles = 0;
   bit                 hold_request = 0;
   bit                 hold_done = 0;
   pvf_pkg::means_type cur_means = '0;

   partial_volume_fraction_voxel #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pvf_voxel_checker #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // End the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_partial_volume_fraction_voxel: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stalls, one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_request && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one register write and hold it until taken; caller drops valid
   task automatic write_reg(input logic [pvf_pkg::IDX_W-1:0] idx,
                            input logic [pvf_pkg::INT_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic set_means(input logic [pvf_pkg::INT_W-1:0] csf, gm, wm,
                            input bit touch_spare);
      write_reg(pvf_pkg::REG_MEAN_CSF, csf);
      write_reg(pvf_pkg::REG_MEAN_GM, gm);
      write_reg(pvf_pkg::REG_MEAN_WM, wm);
      if (touch_spare) write_reg(REG_UNUSED, pvf_pkg::INT_W'($urandom));
      csr_chan.valid <= 1'b0;
      cur_means = '{mean_csf: csf, mean_gm: gm, mean_wm: wm};
   endtask

   // Offer one voxel beat and hold it until taken; caller drops valid
   task automatic send_voxel(input logic [pvf_pkg::INT_W-1:0] x,
                             input logic [pvf_pkg::CODE_W-1:0] code,
                             input logic last);
      req_chan.valid       <= 1'b1;
      req_chan.intensity   <= x;
      req_chan.tissue_code <= code;
      req_chan.last_voxel  <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic maybe_pause();
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every queued prediction has been retired
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // Intensity near the two means of a mix code, sometimes anywhere in range; other codes take any intensity
   function automatic logic [pvf_pkg::INT_W-1:0] pick_intensity(
      input logic [pvf_pkg::CODE_W-1:0] code);
      int lo;
      int hi;
      int v;
      int r;
      lo = (code == pvf_pkg::CODE_WM_GM) ? cur_means.mean_gm : cur_means.mean_csf;
      hi = (code == pvf_pkg::CODE_WM_GM) ? cur_means.mean_wm : cur_means.mean_gm;
      r  = $urandom_range(0, 19);
      if (r < 5 || (code != pvf_pkg::CODE_GM_CSF && code != pvf_pkg::CODE_WM_GM))
         v = $urandom_range(0, 65535);
      else if (r < 14) v = $urandom_range(lo, hi);
      else if (r < 16) v = $urandom_range(0, 1) ? lo : hi;
      else v = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return pvf_pkg::INT_W'(v);
   endfunction

   function automatic logic [pvf_pkg::CODE_W-1:0] pick_code();
      int r;
      r = $urandom_range(0, 11);
      if (r < 4) return pvf_pkg::CODE_GM_CSF;
      if (r < 8) return pvf_pkg::CODE_WM_GM;
      return pvf_pkg::CODE_W'($urandom_range(0, 7));
   endfunction

   initial begin
      logic [pvf_pkg::CODE_W-1:0] code;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.intensity   <= '0;
      req_chan.tissue_code <= pvf_pkg::CODE_BG;
      req_chan.last_voxel  <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= pvf_pkg::REG_MEAN_CSF;
      csr_chan.data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: pure codes, spare codes, and each clamp of the mix fraction.
      // WM/GM shares one mean so its divisor is zero.
      set_means(16'd1000, 16'd3000, 16'd3000, 1'b0);
      idle_pct = 15;
      send_voxel(16'd0, pvf_pkg::CODE_BG, 1'b0);
      send_voxel(16'hFFFF, pvf_pkg::CODE_BG, 1'b1);
      send_voxel(16'd100, pvf_pkg::CODE_CSF, 1'b0);
      send_voxel(16'd100, pvf_pkg::CODE_GM, 1'b0);
      send_voxel(16'hFFFF, pvf_pkg::CODE_WM, 1'b1);
      send_voxel(16'hFFFF, CODE_SPARE_LO, 1'b0);
      send_voxel(16'd0, CODE_SPARE_HI, 1'b1);
      send_voxel(16'd1000, pvf_pkg::CODE_GM_CSF, 1'b0);
      send_voxel(16'd2000, pvf_pkg::CODE_GM_CSF, 1'b0);
      maybe_pause();
      send_voxel(16'd2001, pvf_pkg::CODE_GM_CSF, 1'b0);
      send_voxel(16'd1500, pvf_pkg::CODE_GM_CSF, 1'b0);
      send_voxel(16'd500, pvf_pkg::CODE_GM_CSF, 1'b0);
      send_voxel(16'd3000, pvf_pkg::CODE_GM_CSF, 1'b0);
      send_voxel(16'hFFFF, pvf_pkg::CODE_GM_CSF, 1'b1);
      send_voxel(16'd0, pvf_pkg::CODE_GM_CSF, 1'b0);
      maybe_pause();
      send_voxel(16'd4000, pvf_pkg::CODE_WM_GM, 1'b0);
      send_voxel(16'd2000, pvf_pkg::CODE_WM_GM, 1'b0);
      send_voxel(16'd3000, pvf_pkg::CODE_WM_GM, 1'b0);
      send_voxel(16'hFFFF, pvf_pkg::CODE_WM_GM, 1'b0);
      send_voxel(16'd0, pvf_pkg::CODE_WM_GM, 1'b1);
      drain();

      // Random sets: extremes first, then random means; the last set runs without idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       set_means(16'd0, 16'hFFFF, 16'd0, 1'b0);
            1:       set_means(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
            2:       set_means(16'd40000, 16'd40000, 16'd40000, 1'b0);
            3:       set_means(16'd100, 16'd101, 16'd103, 1'b1);
            default: set_means(pvf_pkg::INT_W'($urandom), pvf_pkg::INT_W'($urandom),
                               pvf_pkg::INT_W'($urandom), 1'b0);
         endcase
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 8;
            default: idle_pct = 30;
         endcase
         if (p == 0) begin
            idle_pct     = 10;
            hold_request = 1;
         end
         if (p == RANDOM_PHASES - 1) idle_pct = 0;
         for (int i = 0; i < VOXELS_PER_SET; i++) begin
            code = pick_code();
            send_voxel(pick_intensity(code), code,
                       (i == VOXELS_PER_SET - 1) || ($urandom_range(0, 15) == 0));
            if (i != VOXELS_PER_SET - 1) maybe_pause();
         end
         drain();
      end

      // Let any stray result beat show up before the verdict
      repeat (LATENCY + 2) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_partial_volume_fraction_voxel: PASS");
      end else begin
         $display("tb_partial_volume_fraction_voxel: FAIL");
      end
      $finish;
   end

endmodule
